### rtl/core/bfdm_pkg.sv
// Package for the brute-force descriptor matcher: sizes, CSR indexes and
// widths shared by the interfaces, the cell chain and the top level. No dependencies.
`default_nettype none
package bfdm_pkg;
   localparam int NUM_REFS  = 64;
   localparam int MAX_DIM   = 128;
   localparam int ELEM_W    = 8;
   localparam int SLOT_W    = 6;
   localparam int POS_W     = 7;
   localparam int ADDR_W    = SLOT_W + POS_W;
   localparam int DIST_W    = 23;
   localparam int THR_W     = 24;
   localparam int COUNT_W   = 7;
   localparam int LEN_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
   localparam logic [COUNT_W-1:0] REFS_LIMIT    = COUNT_W'(NUM_REFS);
   localparam logic [LEN_W-1:0]   LEN_LIMIT     = LEN_W'(MAX_DIM);
   localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(NUM_REFS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_LEN  = 2'd2;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
endpackage
`default_nettype wire

### rtl/core/bfdm_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on bfdm_pkg.
`default_nettype none
interface bfdm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [bfdm_pkg::SLOT_W-1:0]   ref_slot;
   logic [bfdm_pkg::POS_W-1:0]    elem_index;
   logic [bfdm_pkg::ELEM_W-1:0]   elem_value;
   modport source (output valid, mode, ref_slot, elem_index, elem_value, input ready);
   modport sink   (input valid, mode, ref_slot, elem_index, elem_value, output ready);
endinterface

interface bfdm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          matched;
   logic [bfdm_pkg::SLOT_W-1:0]   best_index;
   logic [bfdm_pkg::DIST_W-1:0]   best_distance;
   modport source (output valid, matched, best_index, best_distance, input ready);
   modport sink   (input valid, matched, best_index, best_distance, output ready);
endinterface
`default_nettype wire

### rtl/core/bfdm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bfdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

### rtl/core/bfdm_cell.sv
// One partial-distance cell of the ring; shifts toward its neighbor on enable.
// Depends on bfdm_pkg.
`default_nettype none
module bfdm_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire logic [bfdm_pkg::DIST_W-1:0] d_in,
   output logic      [bfdm_pkg::DIST_W-1:0] q
);
   logic [bfdm_pkg::DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
      end else if (shift_en) begin
         dist_ff <= d_in;
      end
   end

   assign q = dist_ff;
endmodule
`default_nettype wire

### rtl/core/brute_force_descriptor_matcher_unit.sv
// Brute-force nearest-neighbor matcher on squared L2 distance. Load beats
// (mode 0) write one reference element into the store. A query beat runs
// one pass over all 64 slots of a ring of partial-distance cells, one slot
// per cycle behind a registered read from the single read port of the
// reference store. The pass for the last element also picks the nearest
// slot and clears the ring; its response waits in an output register while
// new beats are taken.
`default_nettype none
module brute_force_descriptor_matcher_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [bfdm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bfdm_pkg::THR_W-1:0]     csr_write_data,
   bfdm_req_if.sink                            req_bus,
   bfdm_rsp_if.source                          rsp_bus
);
   typedef enum logic [1:0] {IDLE, RUN, DONE} state_type;

   state_type                      state_ff, state_in;
   logic [bfdm_pkg::THR_W-1:0]     thr_ff;
   logic [bfdm_pkg::COUNT_W-1:0]   ref_count_ff;
   logic [bfdm_pkg::LEN_W-1:0]     desc_len_ff;
   logic [bfdm_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [bfdm_pkg::ELEM_W-1:0]    val_ff, val_in;
   logic                           last_ff, last_in;
   logic [bfdm_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [bfdm_pkg::SLOT_W-1:0]    rd_slot_ff, rd_slot_in;
   logic [bfdm_pkg::DIST_W-1:0]    best_ff, best_in;
   logic [bfdm_pkg::SLOT_W-1:0]    best_idx_ff, best_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_matched_ff, rsp_matched_in;
   logic [bfdm_pkg::SLOT_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [bfdm_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;

   logic [bfdm_pkg::COUNT_W-1:0]   n_use;
   logic [bfdm_pkg::LEN_W-1:0]     len_use;
   logic                           accept, issue;
   logic [bfdm_pkg::ADDR_W-1:0]    waddr, raddr;
   logic [bfdm_pkg::ELEM_W-1:0]    ref_elem, diff;
   logic [2*bfdm_pkg::ELEM_W-1:0]  sq;
   logic [bfdm_pkg::DIST_W:0]      sum;
   logic [bfdm_pkg::DIST_W-1:0]    sum_sat, tail_in;
   logic                           slot_used;
   logic [bfdm_pkg::DIST_W-1:0]    ring_q [bfdm_pkg::NUM_REFS];

   assign n_use   = (ref_count_ff > bfdm_pkg::REFS_LIMIT) ? bfdm_pkg::REFS_LIMIT
                                                            : ref_count_ff;
   assign len_use = (desc_len_ff == '0) ? bfdm_pkg::LEN_W'(1)
                  : (desc_len_ff > bfdm_pkg::LEN_LIMIT) ? bfdm_pkg::LEN_LIMIT : desc_len_ff;

   assign req_bus.ready = (state_ff == IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign issue         = (state_ff == RUN) && !cnt_ff[bfdm_pkg::COUNT_W-1];
   assign waddr         = {req_bus.ref_slot, req_bus.elem_index};
   assign raddr         = {cnt_ff[bfdm_pkg::SLOT_W-1:0], pos_ff};

   bfdm_ram #(.WIDTH(bfdm_pkg::ELEM_W), .DEPTH(bfdm_pkg::NUM_REFS * bfdm_pkg::MAX_DIM))
   u_store (
      .clock (clock),
      .we    (accept && (req_bus.mode == bfdm_pkg::MODE_LOAD)),
      .waddr (waddr),
      .wdata (req_bus.elem_value),
      .re    (issue),
      .raddr (raddr),
      .rdata (ref_elem)
   );

   assign diff      = (val_ff > ref_elem) ? (val_ff - ref_elem) : (ref_elem - val_ff);
   assign sq        = diff * diff;
   assign sum       = {1'b0, ring_q[0]} + (bfdm_pkg::DIST_W + 1)'(sq);
   assign sum_sat   = sum[bfdm_pkg::DIST_W] ? bfdm_pkg::DIST_MAX : sum[bfdm_pkg::DIST_W-1:0];
   assign slot_used = {1'b0, rd_slot_ff} < n_use;
   assign tail_in   = last_ff ? '0 : (slot_used ? sum_sat : ring_q[0]);

   for (genvar i = 0; i < bfdm_pkg::NUM_REFS; i++) begin : g_ring
      bfdm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (rd_valid_ff),
         .d_in     ((i == bfdm_pkg::NUM_REFS - 1) ? tail_in : ring_q[(i + 1) % bfdm_pkg::NUM_REFS]),
         .q        (ring_q[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      last_in        = last_ff;
      cnt_in         = cnt_ff;
      rd_valid_in    = issue;
      rd_slot_in     = cnt_ff[bfdm_pkg::SLOT_W-1:0];
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_dist_in    = rsp_dist_ff;
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (rd_valid_ff && last_ff && slot_used
          && (rd_slot_ff == '0 || sum_sat < best_ff)) begin
         best_in     = sum_sat;
         best_idx_in = rd_slot_ff;
      end
      unique case (state_ff)
         IDLE: begin
            if (accept && req_bus.mode == bfdm_pkg::MODE_QUERY
                && {1'b0, req_bus.elem_index} < len_use) begin
               state_in    = RUN;
               pos_in      = req_bus.elem_index;
               val_in      = req_bus.elem_value;
               last_in     = ({1'b0, req_bus.elem_index} == len_use - 1'b1);
               cnt_in      = '0;
               best_in     = '0;
               best_idx_in = '0;
            end
         end
         RUN: begin
            if (rd_valid_ff && rd_slot_ff == bfdm_pkg::LAST_SLOT) begin
               state_in = last_ff ? DONE : IDLE;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in       = IDLE;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = (n_use != '0) && ({1'b0, best_ff} <= thr_ff);
               rsp_idx_in     = best_idx_ff;
               rsp_dist_in    = best_ff;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         thr_ff       <= '1;
         ref_count_ff <= '0;
         desc_len_ff  <= bfdm_pkg::LEN_LIMIT;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               bfdm_pkg::CSR_THRESHOLD: thr_ff <= csr_write_data;
               bfdm_pkg::CSR_REF_COUNT: ref_count_ff <= csr_write_data[bfdm_pkg::COUNT_W-1:0];
               bfdm_pkg::CSR_DESC_LEN:  desc_len_ff <= csr_write_data[bfdm_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
      end
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      last_ff        <= last_in;
      rd_slot_ff     <= rd_slot_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.matched       = rsp_matched_ff;
   assign rsp_bus.best_index    = rsp_idx_ff;
   assign rsp_bus.best_distance = rsp_dist_ff;
endmodule
`default_nettype wire

### rtl/core/bfdm_checker.sv
// Port-level checks for the matcher top level, bound onto it.
// Depends on bfdm_pkg and the matcher top level.
`default_nettype none
module bfdm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_matched,
   input wire logic [bfdm_pkg::SLOT_W-1:0]   rsp_best_index,
   input wire logic [bfdm_pkg::DIST_W-1:0]   rsp_best_distance
);
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_matched) && $stable(rsp_best_index)
                                  && $stable(rsp_best_distance))
      else $error("response payload changed while stalled");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == bfdm_pkg::MODE_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("load beat produced a response");
endmodule

bind brute_force_descriptor_matcher_unit bfdm_checker u_bfdm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_mode          (req_bus.mode),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_matched       (rsp_bus.matched),
   .rsp_best_index    (rsp_bus.best_index),
   .rsp_best_distance (rsp_bus.best_distance)
);
`default_nettype wire
